>>> design/bounding_sphere_centroid_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef BOUNDING_SPHERE_CENTROID_DEFINES_SVH
`define BOUNDING_SPHERE_CENTROID_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked at the clock edge after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/bsc_pkg.sv
// Package for the bounding sphere centroid block: sizes, types, queue entry.
// No dependencies.
package bsc_pkg;
   localparam int MaxVerts = 1024;
   localparam int AddrW = $clog2(MaxVerts);
   localparam int CountW = AddrW + 1;
   localparam int SumW = 16 + CountW;
   localparam int QueueDepth = 4;
   localparam int QPtrW = $clog2(QueueDepth);

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } vertex_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] center_z;
      logic [17:0]        radius;
      logic               overflow;
   } result_type;

   // Front to back: one classified transaction.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               store;
      logic               last;
   } cmd_type;
endpackage

>>> design/bsc_if.sv
// Valid/ready channel interface carrying a payload of a chosen type.
// Depends on nothing; payload types come from bsc_pkg at instantiation.
interface bsc_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/bsc_front.sv
// Front: accepts vertices, tracks fill level, classifies store or drop.
// Depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  vertex_type in_data,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd_data
);
   logic [CountW-1:0] fill_ff, fill_in;

   assign in_ready = cmd_ready;
   assign cmd_valid = in_valid;
   always_comb begin
      cmd_data.x = in_data.x;
      cmd_data.y = in_data.y;
      cmd_data.z = in_data.z;
      cmd_data.last = in_data.last;
      cmd_data.store = (fill_ff != CountW'(MaxVerts));
      fill_in = fill_ff;
      if (in_valid && cmd_ready) begin
         if (in_data.last) fill_in = '0;
         else if (cmd_data.store) fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else fill_ff <= fill_in;
   end
endmodule

>>> design/bsc_queue.sv
// Short FIFO between front and back.
// Depends on bsc_pkg.
module bsc_queue import bsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_data
);
   cmd_type            mem_ff [QueueDepth];
   logic [QPtrW-1:0]   wp_ff, rp_ff;
   logic [QPtrW:0]     cnt_ff;
   logic               push, pop;

   assign wr_ready = (cnt_ff != (QPtrW+1)'(QueueDepth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end
endmodule

>>> design/bsc_back.sv
// Back: vertex store, running sums, divide, distance scan, square root.
// Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);
   typedef enum logic [5:0] {
      ST_LOAD = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_SQRT = 6'b001000,
      ST_OUT  = 6'b010000,
      ST_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [47:0] mem [MaxVerts];
   logic [47:0] rd_ff;
   logic signed [SumW-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [SumW-1:0] tx, ty, tz;
   logic [CountW-1:0] count_ff;
   logic drop_ff;
   // Divider: restoring, one quotient bit per cycle for three axes.
   logic [SumW-1:0] qx_ff, qy_ff, qz_ff, rx_ff, ry_ff, rz_ff;
   logic [SumW-1:0] rx_in, ry_in, rz_in;
   logic nx_ff, ny_ff, nz_ff;
   logic [4:0] step_ff;
   logic signed [15:0] cx_ff, cy_ff, cz_ff;
   // Scan pipeline.
   logic [CountW-1:0] rdix_ff;
   logic rdv_ff, dv_ff;
   logic [16:0] ax_ff, ay_ff, az_ff;
   logic [33:0] px_ff, py_ff, pz_ff;
   logic pv_ff;
   logic [35:0] best_ff, dsum;
   // Square root.
   logic [35:0] sv_ff, sroot_ff, sbit_ff;
   result_type res_ff;
   logic accept;

   assign cmd_ready = (state_ff == ST_LOAD);
   assign accept = cmd_valid && cmd_ready;
   assign out_valid = (state_ff == ST_WAIT);
   assign out_data = res_ff;

   function automatic logic [SumW-1:0] absv(logic signed [SumW-1:0] v);
      return v[SumW-1] ? SumW'(-v) : SumW'(v);
   endfunction

   function automatic logic [16:0] adiff(logic signed [15:0] a,
                                         logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   function automatic logic [SumW-1:0] dstep(logic [SumW-1:0] r, logic b,
                                             logic [CountW-1:0] n);
      logic [SumW:0] t;
      t = {r, b};
      if (t >= (SumW+1)'(n)) t = t - (SumW+1)'(n);
      return t[SumW-1:0];
   endfunction

   function automatic logic signed [15:0] sgn(logic [SumW-1:0] q, logic n);
      logic [SumW-1:0] v;
      v = n ? -q : q;
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (accept && cmd_data.store)
         mem[count_ff[AddrW-1:0]] <= {cmd_data.x, cmd_data.y, cmd_data.z};
      rd_ff <= mem[rdix_ff[AddrW-1:0]];
   end

   // Sums including the transaction on the input, when it is stored.
   assign tx = cmd_data.store ? sx_ff + SumW'(cmd_data.x) : sx_ff;
   assign ty = cmd_data.store ? sy_ff + SumW'(cmd_data.y) : sy_ff;
   assign tz = cmd_data.store ? sz_ff + SumW'(cmd_data.z) : sz_ff;

   assign rx_in = dstep(rx_ff, qx_ff[SumW-1], count_ff);
   assign ry_in = dstep(ry_ff, qy_ff[SumW-1], count_ff);
   assign rz_in = dstep(rz_ff, qz_ff[SumW-1], count_ff);
   assign dsum = 36'(px_ff) + 36'(py_ff) + 36'(pz_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (accept && cmd_data.last) state_in = ST_DIV;
         ST_DIV:  if (step_ff == 5'(SumW)) state_in = ST_SCAN;
         ST_SCAN: if (rdix_ff >= count_ff && !rdv_ff && !dv_ff && !pv_ff)
                     state_in = ST_SQRT;
         ST_SQRT: if (sbit_ff == '0) state_in = ST_OUT;
         ST_OUT:  state_in = ST_WAIT;
         ST_WAIT: if (out_ready) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
         count_ff <= '0;
         drop_ff <= 1'b0;
         rdv_ff <= 1'b0; dv_ff <= 1'b0; pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: if (accept) begin
               if (cmd_data.store) begin
                  sx_ff <= sx_ff + SumW'(cmd_data.x);
                  sy_ff <= sy_ff + SumW'(cmd_data.y);
                  sz_ff <= sz_ff + SumW'(cmd_data.z);
                  count_ff <= count_ff + 1'b1;
               end else drop_ff <= 1'b1;
            end
            ST_SCAN: begin
               rdv_ff <= (rdix_ff < count_ff);
               dv_ff <= rdv_ff;
               pv_ff <= dv_ff;
            end
            ST_WAIT: if (out_ready) begin
               sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
               count_ff <= '0;
               drop_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            step_ff <= '0;
            rx_ff <= '0; ry_ff <= '0; rz_ff <= '0;
            rdix_ff <= '0;
            best_ff <= '0;
            if (accept && cmd_data.last) begin
               qx_ff <= absv(tx);
               qy_ff <= absv(ty);
               qz_ff <= absv(tz);
               nx_ff <= tx[SumW-1];
               ny_ff <= ty[SumW-1];
               nz_ff <= tz[SumW-1];
            end
         end
         ST_DIV: begin
            if (step_ff != 5'(SumW)) begin
               step_ff <= step_ff + 1'b1;
               rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
               qx_ff <= {qx_ff[SumW-2:0], ({rx_ff, qx_ff[SumW-1]} >= (SumW+1)'(count_ff))};
               qy_ff <= {qy_ff[SumW-2:0], ({ry_ff, qy_ff[SumW-1]} >= (SumW+1)'(count_ff))};
               qz_ff <= {qz_ff[SumW-2:0], ({rz_ff, qz_ff[SumW-1]} >= (SumW+1)'(count_ff))};
            end else begin
               cx_ff <= sgn(qx_ff, nx_ff);
               cy_ff <= sgn(qy_ff, ny_ff);
               cz_ff <= sgn(qz_ff, nz_ff);
            end
         end
         ST_SCAN: begin
            if (rdix_ff < count_ff) rdix_ff <= rdix_ff + 1'b1;
            ax_ff <= adiff(cx_ff, rd_ff[47:32]);
            ay_ff <= adiff(cy_ff, rd_ff[31:16]);
            az_ff <= adiff(cz_ff, rd_ff[15:0]);
            px_ff <= ax_ff * ax_ff;
            py_ff <= ay_ff * ay_ff;
            pz_ff <= az_ff * az_ff;
            if (pv_ff && dsum > best_ff) best_ff <= dsum;
            // The last scan cycle has no product in flight, so best is final.
            sv_ff <= best_ff;
            sroot_ff <= '0;
            sbit_ff <= 36'h4_0000_0000;
         end
         ST_SQRT: begin
            if (sbit_ff != '0) begin
               if (sv_ff >= sroot_ff + sbit_ff) begin
                  sv_ff <= sv_ff - (sroot_ff + sbit_ff);
                  sroot_ff <= (sroot_ff >> 1) + sbit_ff;
               end else sroot_ff <= sroot_ff >> 1;
               sbit_ff <= sbit_ff >> 2;
            end
         end
         ST_OUT: begin
            res_ff.center_x <= cx_ff;
            res_ff.center_y <= cy_ff;
            res_ff.center_z <= cz_ff;
            res_ff.radius <= sroot_ff[17:0];
            res_ff.overflow <= drop_ff;
         end
         default: ;
      endcase
   end
endmodule

>>> design/bounding_sphere_centroid.sv
// Top level of the centroid bounding sphere block.
// Depends on bsc_pkg, bsc_if, bsc_front, bsc_queue, bsc_back.
//
// channel   dir  payload
// req_      in   x, y, z (Q8.8 signed), last
// rsp_      out  center_x/y/z (Q8.8), radius (Q.8), overflow
//
// Vertices load one per cycle into the vertex memory while running sums
// accumulate, as long as the back end is loading and the queue is not empty.
// A last vertex starts the end-of-mesh work: divide, a scan over the N
// stored vertices (one memory read port), square root, then the result
// register. Reset is synchronous; the memory needs no clearing.
// A four-entry queue lets req_ keep filling while the back end is busy;
// a stalled rsp_ holds the result.
module bounding_sphere_centroid import bsc_pkg::*; (
   input  logic clock,
   input  logic reset,
   bsc_if.sink   req,
   bsc_if.source rsp
);
   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_data, q_data;

   // Classify: store or drop based on fill level.
   bsc_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   // Decouple front and back.
   bsc_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   // Carry out: store, sum, divide, scan, root.
   bsc_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

>>> design/bsc_checker.sv
// Port checker for bounding_sphere_centroid, bound to the top level.
// Depends on bsc_pkg and the macro header.
`include "bounding_sphere_centroid_defines.svh"
module bsc_checker import bsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input result_type rsp_data
);
   `BSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BSC_ASSERT_IMPL(a_radius_range, clock, reset, rsp_valid, rsp_data.radius <= 18'd227023)
   `BSC_ASSERT_NEXT(a_one_result, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
endmodule

bind bounding_sphere_centroid bsc_checker u_bsc_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
